// ===== rtl/lpp_pkg.sv =====
// Package with widths, register indices and payload types for the point-to-pixel projector.
`timescale 1ns / 1ps
package lpp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int COEF_BITS   = 32;
    localparam int NUM_REGS    = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 2 * COEF_BITS;

    // Exact product, four-term row sum, shifted numerator and division widths.
    localparam int PROD_W = COORD_WIDTH + COEF_BITS;
    localparam int ROW_W  = PROD_W + 2;
    localparam int NUM_W  = ROW_W + FRAC_BITS;
    localparam int QW     = COORD_WIDTH + 1;
    localparam int REM_W  = ROW_W + 1;
    localparam int CMP_W  = ROW_W + QW;

    localparam logic [CFG_IDX_W-1:0] REG_R0_C01 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_R0_C23 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_R1_C01 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_R1_C23 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_R2_C01 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_R2_C23 = CFG_IDX_W'(5);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pixel_u;
        logic signed [COORD_WIDTH-1:0] pixel_v;
        t_status                       status;
    } t_pixel;

endpackage

// ===== rtl/lpp_div.sv =====
// Pipelined restoring divider giving one quotient bit per stage.
`timescale 1ns / 1ps
module lpp_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [lpp_pkg::NUM_W-1:0] i_num,
    input  logic [lpp_pkg::ROW_W-1:0] i_den,
    input  logic                      i_ovf,
    output logic [lpp_pkg::QW-1:0]    o_quo,
    output logic                      o_ovf
);
    import lpp_pkg::*;

    logic [REM_W-1:0] r_rem [0:QW-1];
    logic [NUM_W-1:0] r_num [0:QW-1];
    logic [ROW_W-1:0] r_den [0:QW-1];
    logic [QW-1:0]    r_quo [0:QW-1];
    logic             r_ovf [0:QW-1];

    logic [REM_W-1:0] n_rem [0:QW-1];
    logic [QW-1:0]    n_quo [0:QW-1];
    logic [NUM_W-1:0] w_pnum [0:QW-1];
    logic [ROW_W-1:0] w_pden [0:QW-1];
    logic             w_povf [0:QW-1];

    always_comb begin
        logic [REM_W-1:0] prem;
        logic [QW-1:0]    pquo;
        logic [REM_W-1:0] trial;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                // The bits above the quotient range are below the divisor once overflow is excluded.
                prem      = REM_W'(i_num >> QW);
                pquo      = '0;
                w_pnum[k] = i_num;
                w_pden[k] = i_den;
                w_povf[k] = i_ovf;
            end else begin
                prem      = r_rem[k-1];
                pquo      = r_quo[k-1];
                w_pnum[k] = r_num[k-1];
                w_pden[k] = r_den[k-1];
                w_povf[k] = r_ovf[k-1];
            end
            trial = {prem[REM_W-2:0], w_pnum[k][QW-1-k]};
            if (trial >= {1'b0, w_pden[k]}) begin
                n_rem[k] = trial - {1'b0, w_pden[k]};
                n_quo[k] = {pquo[QW-2:0], 1'b1};
            end else begin
                n_rem[k] = trial;
                n_quo[k] = {pquo[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_num[k] <= w_pnum[k];
                r_den[k] <= w_pden[k];
                r_ovf[k] <= w_povf[k];
            end
        end
    end

    assign o_quo = r_quo[QW-1];
    assign o_ovf = r_ovf[QW-1];

endmodule

// ===== rtl/lidar_point_to_pixel_top.sv =====
// Pipeline: 4 arithmetic stages, 33 divider stages and an output register between input transfer and result.
// Throughput: one point per cycle; the whole pipeline holds while a result is stalled.
// Most of the latency is the 33-stage restoring divider, which resolves one quotient bit per stage.
// Reset clears the valid bits and the six coefficient registers to zero.
// Configuration writes are always ready and take effect on the next cycle.
`timescale 1ns / 1ps
module lidar_point_to_pixel_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lpp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lpp_pkg::t_point               i_point,
    output logic                          o_pix_valid,
    input  logic                          i_pix_stall,
    output lpp_pkg::t_pixel               o_pixel
);
    import lpp_pkg::*;

    logic [CFG_DATA_W-1:0] r_cfg [0:NUM_REGS-1];
    logic                  w_en;

    logic signed [COEF_BITS-1:0]   w_coef [0:2][0:3];
    logic signed [COORD_WIDTH-1:0] w_x    [0:2];

    logic                     r_a_vld;
    logic signed [PROD_W-1:0] r_prod [0:2][0:2];
    logic signed [ROW_W-1:0]  r_bias [0:2];

    logic                    r_b_vld;
    logic signed [ROW_W-1:0] r_row [0:2];

    logic             r_c_vld, r_c_zero, r_c_negu, r_c_negv;
    logic [NUM_W-1:0] r_c_nu, r_c_nv;
    logic [ROW_W-1:0] r_c_d;

    logic             r_d_vld, r_d_zero, r_d_negu, r_d_negv, r_d_ovfu, r_d_ovfv;
    logic [NUM_W-1:0] r_d_nu, r_d_nv;
    logic [ROW_W-1:0] r_d_d;

    logic r_s_vld [0:QW-1];
    logic r_s_zero [0:QW-1];
    logic r_s_negu [0:QW-1];
    logic r_s_negv [0:QW-1];

    logic [QW-1:0] w_qu, w_qv;
    logic          w_ovfu, w_ovfv;
    logic          w_satu, w_satv;
    logic [QW-1:0] w_limu, w_limv, w_valu, w_valv;
    t_pixel        n_out;

    logic   r_out_vld;
    t_pixel r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_R0_C01: r_cfg[0] <= i_cfg_data;
                REG_R0_C23: r_cfg[1] <= i_cfg_data;
                REG_R1_C01: r_cfg[2] <= i_cfg_data;
                REG_R1_C23: r_cfg[3] <= i_cfg_data;
                REG_R2_C01: r_cfg[4] <= i_cfg_data;
                REG_R2_C23: r_cfg[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline moves as one; it holds only while the result waits to be taken.
    assign w_en       = !(r_out_vld && i_pix_stall);
    assign o_in_stall = !w_en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 4; j++) begin
                w_coef[i][j] = r_cfg[i*2 + j/2][COEF_BITS*(j%2) +: COEF_BITS];
            end
        end
        w_x[0] = i_point.point_x;
        w_x[1] = i_point.point_y;
        w_x[2] = i_point.point_z;
    end

    // Stage A: the nine exact products and the translation terms.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= w_coef[i][j] * w_x[j];
                end
                r_bias[i] <= ROW_W'(w_coef[i][3]) <<< FRAC_BITS;
            end
        end
    end

    // Stage B: row sums.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_row[i] <= ROW_W'(r_prod[i][0]) + ROW_W'(r_prod[i][1])
                          + ROW_W'(r_prod[i][2]) + r_bias[i];
            end
        end
    end

    // Stage C: signs, magnitudes and the scaled numerators.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_zero <= (r_row[2] == '0);
            r_c_negu <= r_row[0][ROW_W-1] ^ r_row[2][ROW_W-1];
            r_c_negv <= r_row[1][ROW_W-1] ^ r_row[2][ROW_W-1];
            r_c_nu   <= {(r_row[0][ROW_W-1] ? ROW_W'(-r_row[0]) : ROW_W'(r_row[0])),
                         FRAC_BITS'(0)};
            r_c_nv   <= {(r_row[1][ROW_W-1] ? ROW_W'(-r_row[1]) : ROW_W'(r_row[1])),
                         FRAC_BITS'(0)};
            r_c_d    <= r_row[2][ROW_W-1] ? ROW_W'(-r_row[2]) : ROW_W'(r_row[2]);
        end
    end

    // Stage D: a quotient that needs more than QW bits saturates without division.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_zero <= r_c_zero;
            r_d_negu <= r_c_negu;
            r_d_negv <= r_c_negv;
            r_d_nu   <= r_c_nu;
            r_d_nv   <= r_c_nv;
            r_d_d    <= r_c_d;
            r_d_ovfu <= CMP_W'(r_c_nu) >= {r_c_d, QW'(0)};
            r_d_ovfv <= CMP_W'(r_c_nv) >= {r_c_d, QW'(0)};
        end
    end

    lpp_div u_div_u (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_d_nu),
        .i_den (r_d_d),
        .i_ovf (r_d_ovfu),
        .o_quo (w_qu),
        .o_ovf (w_ovfu)
    );

    lpp_div u_div_v (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_d_nv),
        .i_den (r_d_d),
        .i_ovf (r_d_ovfv),
        .o_quo (w_qv),
        .o_ovf (w_ovfv)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < QW; k++) begin
                if (k == 0) begin
                    r_s_zero[k] <= r_d_zero;
                    r_s_negu[k] <= r_d_negu;
                    r_s_negv[k] <= r_d_negv;
                end else begin
                    r_s_zero[k] <= r_s_zero[k-1];
                    r_s_negu[k] <= r_s_negu[k-1];
                    r_s_negv[k] <= r_s_negv[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < QW; k++) begin
                r_s_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_a_vld <= i_in_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            for (int k = 0; k < QW; k++) begin
                r_s_vld[k] <= (k == 0) ? r_d_vld : r_s_vld[k-1];
            end
            r_out_vld <= r_s_vld[QW-1];
        end
    end

    // Saturation bounds: 2^(W-1) for a negative quotient, 2^(W-1)-1 otherwise.
    always_comb begin
        w_limu = r_s_negu[QW-1] ? (QW'(1) << (COORD_WIDTH-1))
                                : ((QW'(1) << (COORD_WIDTH-1)) - QW'(1));
        w_limv = r_s_negv[QW-1] ? (QW'(1) << (COORD_WIDTH-1))
                                : ((QW'(1) << (COORD_WIDTH-1)) - QW'(1));
        w_satu = w_ovfu || (w_qu > w_limu);
        w_satv = w_ovfv || (w_qv > w_limv);
        w_valu = w_satu ? w_limu : w_qu;
        w_valv = w_satv ? w_limv : w_qv;
        if (r_s_zero[QW-1]) begin
            n_out.pixel_u = '0;
            n_out.pixel_v = '0;
            n_out.status  = ST_ZERO;
        end else begin
            n_out.pixel_u = r_s_negu[QW-1] ? COORD_WIDTH'(-w_valu) : COORD_WIDTH'(w_valu);
            n_out.pixel_v = r_s_negv[QW-1] ? COORD_WIDTH'(-w_valv) : COORD_WIDTH'(w_valv);
            n_out.status  = (w_satu || w_satv) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_pix_valid = r_out_vld;
    assign o_pixel     = r_out;

    a_zero_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_valid && o_pixel.status == ST_ZERO |-> o_pixel.pixel_u == '0
                                                  && o_pixel.pixel_v == '0)
        else $error("zero-depth result carries a nonzero pixel");

    a_ovf_is_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_s_vld[QW-1] && !r_s_zero[QW-1] && (w_ovfu || w_ovfv)
        |=> o_pixel.status == ST_SAT)
        else $error("divider overflow did not give saturated status");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_d_vld) && $stable(r_s_vld[QW-1]))
        else $error("pipeline moved while the result was stalled");

    a_pass_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_s_vld[QW-1] |=> o_pix_valid)
        else $error("finished item did not reach the output register");

endmodule
